// ----- rtl/barometric_pressure_compensation_unit_defines.svh -----
// Assertion macros for the barometric pressure compensation unit.
// Used by the top level only; no other dependencies.
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_UNIT_DEFINES_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BPC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bpc_pkg.sv -----
// Shared types, constants and helpers for the pressure compensation unit.
// No dependencies.
`default_nettype none

package bpc_pkg;

    localparam int unsigned DIV_STAGES = 32;

    // Index codes of the configuration registers.
    localparam logic [7:0] REG_CAL_A = 8'd0;
    localparam logic [7:0] REG_CAL_B = 8'd1;
    localparam logic [7:0] REG_CAL_C = 8'd2;
    localparam logic [7:0] REG_OSS   = 8'd3;

    localparam logic [31:0] K_B6_OFFSET = 32'd4000;
    localparam logic [31:0] K_P_C1      = 32'd3038;
    localparam logic [31:0] K_P_C2      = 32'hFFFF_E343; // -7357
    localparam logic [31:0] K_P_C3      = 32'd3791;
    localparam logic [31:0] K_B7_SCALE  = 32'd50000;
    localparam logic [31:0] K_B4_BIAS   = 32'd32768;

    // Sideband that rides through a divider next to the operands.
    typedef struct packed {
        logic [31:0] w0;
        logic [18:0] up;
        logic        f0;
        logic        f1;
        logic        f2;
    } t_side;

    function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
        asr32 = 32'($signed(v) >>> s);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/barometric_pressure_compensation_unit.sv -----
// Barometric pressure compensation unit: top level pipeline and config registers.
// Depends on bpc_pkg, bpc_div_pipe and the assertion macro header.
//
// Usage:
//   Input channel: i_valid with i_raw_temperature / i_raw_pressure; a transfer
//   happens when i_valid is high and o_stall is low.
//   Output channel: o_valid with the three result fields; a transfer happens
//   when o_valid is high and i_stall is low. One result per input item.
//   Config channel: i_cfg_valid, i_cfg_index, i_cfg_data; o_cfg_ready is
//   always high. Index 0..3 = cal_a, cal_b, cal_c, oversampling; others are
//   ignored. Write only while the pipeline is empty.
//   Throughput: one item per cycle while o_stall is low. Depth: 78 register
//   stages, the first loaded by the input transfer; they are made up of
//   two 32-stage bit-per-stage dividers plus 14 other stages.
//   Reset (synchronous, active low) empties the pipeline and clears the
//   configuration registers to zero.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and o_stall rises in the same cycle; nothing is dropped or repeated.
`default_nettype none
`include "barometric_pressure_compensation_unit_defines.svh"

module barometric_pressure_compensation_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [15:0]        i_raw_temperature,
    input  wire logic [18:0]        i_raw_pressure,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_temperature_tenths,
    output logic signed [31:0]      o_baro_pressure,
    output logic                    o_valid_res,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [7:0]         i_cfg_index,
    input  wire logic [63:0]        i_cfg_data
);

    logic [63:0] r_cal_a;
    logic [63:0] r_cal_b;
    logic [31:0] r_cal_c;
    logic [1:0]  r_oss;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
            r_oss   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bpc_pkg::REG_CAL_A: r_cal_a <= i_cfg_data;
                bpc_pkg::REG_CAL_B: r_cal_b <= i_cfg_data;
                bpc_pkg::REG_CAL_C: r_cal_c <= i_cfg_data[31:0];
                bpc_pkg::REG_OSS:   r_oss   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, k50;
    assign ac1 = bpc_pkg::sx16(r_cal_a[15:0]);
    assign ac2 = bpc_pkg::sx16(r_cal_a[31:16]);
    assign ac3 = bpc_pkg::sx16(r_cal_a[47:32]);
    assign ac4 = {16'd0, r_cal_a[63:48]};
    assign ac5 = {16'd0, r_cal_b[15:0]};
    assign ac6 = {16'd0, r_cal_b[31:16]};
    assign b1  = bpc_pkg::sx16(r_cal_b[47:32]);
    assign b2  = bpc_pkg::sx16(r_cal_b[63:48]);
    assign mc  = bpc_pkg::sx16(r_cal_c[15:0]);
    assign md  = bpc_pkg::sx16(r_cal_c[31:16]);
    assign k50 = bpc_pkg::K_B7_SCALE >> r_oss;

    // Global advance: move when the output register is free or being taken.
    logic en;
    logic r_out_v;
    assign en      = !r_out_v || !i_stall;
    assign o_stall = !en;

    // ---------------- front: temperature ----------------
    logic        r0_v, r1_v, r2_v;
    logic [15:0] r0_ut;
    logic [18:0] r0_up, r1_up;
    logic [31:0] r1_x1;
    logic [31:0] r2_num, r2_den;
    bpc_pkg::t_side r2_side;

    logic [31:0] w2_den, w2_num;
    logic        w2_dz;
    assign w2_den = r1_x1 + md;
    assign w2_num = mc << 11;
    assign w2_dz  = (w2_den == 32'd0);

    // ---------------- middle: b3, b4, b7 ----------------
    logic           d1_v;
    logic [31:0]    d1_q;
    bpc_pkg::t_side d1_side;
    logic [31:0]    w3_x2, w3_b5;
    assign w3_x2 = d1_side.f0 ? 32'd0 : (d1_side.f1 ? (32'd0 - d1_q) : d1_q);
    assign w3_b5 = d1_side.w0 + w3_x2;

    logic        r3_v, r4_v, r5_v, r6_v, r7_v, r8_v, r9_v, r10_v;
    logic [31:0] r3_temp, r3_b6;
    logic [18:0] r3_up, r4_up, r5_up, r6_up, r7_up;
    logic        r3_dz, r4_dz, r5_dz, r6_dz, r7_dz, r8_dz, r9_dz;
    logic [31:0] r4_temp, r5_temp, r6_temp, r7_temp, r8_temp, r9_temp;
    logic [31:0] r4_sqr, r4_a2, r4_a3;
    logic [31:0] r5_sq, r5_x2, r5_x1c;
    logic [31:0] r6_b2sq, r6_b1sq, r6_x2, r6_x1c;
    logic [31:0] r7_b3, r7_t;
    logic [31:0] r8_b4, r8_d;
    logic [31:0] r9_b4, r9_b7;
    logic [31:0] r10_num, r10_den;
    bpc_pkg::t_side r10_side;

    logic [31:0] w7_x3, w7_b3, w7_t;
    assign w7_x3 = bpc_pkg::asr32(r6_b2sq, 11) + r6_x2;
    assign w7_b3 = bpc_pkg::asr32((((ac1 << 2) + w7_x3) << r_oss) + 32'd2, 2);
    assign w7_t  = bpc_pkg::asr32(r6_x1c + bpc_pkg::asr32(r6_b1sq, 16) + 32'd2, 2)
                   + bpc_pkg::K_B4_BIAS;

    logic [31:0] w8_prod;
    assign w8_prod = ac4 * r7_t;

    logic w10_b4z;
    assign w10_b4z = (r9_b4 == 32'd0);

    // ---------------- back: pressure correction ----------------
    logic           d2_v;
    logic [31:0]    d2_q;
    bpc_pkg::t_side d2_side;
    logic [31:0]    w11_p, w11_ps;
    assign w11_p  = d2_side.f1 ? (d2_q << 1) : d2_q;
    assign w11_ps = bpc_pkg::asr32(w11_p, 8);

    logic        r11_v, r12_v;
    logic [31:0] r11_p, r11_ps2, r11_m7, r11_temp;
    logic        r11_dz, r11_b4z;
    logic [31:0] r12_p, r12_m3, r12_x2, r12_temp;
    logic        r12_dz, r12_b4z;

    logic [31:0] w13_p;
    logic        w13_ok;
    always_comb begin
        w13_p = r12_p + bpc_pkg::asr32(bpc_pkg::asr32(r12_m3, 16) + r12_x2
                + bpc_pkg::K_P_C3, 4);
        if (r12_b4z) begin
            w13_p = 32'd0;
        end
        w13_ok = !r12_dz && !r12_b4z && (w13_p != 32'd0) && !w13_p[31];
    end

    logic [31:0] r_out_t, r_out_p;
    logic        r_out_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v    <= 1'b0;
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r5_v    <= 1'b0;
            r6_v    <= 1'b0;
            r7_v    <= 1'b0;
            r8_v    <= 1'b0;
            r9_v    <= 1'b0;
            r10_v   <= 1'b0;
            r11_v   <= 1'b0;
            r12_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r0_v    <= i_valid;
            r1_v    <= r0_v;
            r2_v    <= r1_v;
            r3_v    <= d1_v;
            r4_v    <= r3_v;
            r5_v    <= r4_v;
            r6_v    <= r5_v;
            r7_v    <= r6_v;
            r8_v    <= r7_v;
            r9_v    <= r8_v;
            r10_v   <= r9_v;
            r11_v   <= d2_v;
            r12_v   <= r11_v;
            r_out_v <= r12_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_ut <= i_raw_temperature;
            r0_up <= i_raw_pressure;

            r1_x1 <= bpc_pkg::asr32(({16'd0, r0_ut} - ac6) * ac5, 15);
            r1_up <= r0_up;

            // sign-magnitude split for the temperature division
            r2_num       <= w2_num[31] ? (32'd0 - w2_num) : w2_num;
            r2_den       <= w2_dz ? 32'd1 : (w2_den[31] ? (32'd0 - w2_den) : w2_den);
            r2_side.w0   <= r1_x1;
            r2_side.up   <= r1_up;
            r2_side.f0   <= w2_dz;
            r2_side.f1   <= w2_num[31] ^ w2_den[31];
            r2_side.f2   <= 1'b0;

            r3_temp <= bpc_pkg::asr32(w3_b5 + 32'd8, 4);
            r3_b6   <= w3_b5 - bpc_pkg::K_B6_OFFSET;
            r3_up   <= d1_side.up;
            r3_dz   <= d1_side.f0;

            r4_sqr  <= r3_b6 * r3_b6;
            r4_a2   <= ac2 * r3_b6;
            r4_a3   <= ac3 * r3_b6;
            r4_temp <= r3_temp;
            r4_up   <= r3_up;
            r4_dz   <= r3_dz;

            r5_sq   <= bpc_pkg::asr32(r4_sqr, 12);
            r5_x2   <= bpc_pkg::asr32(r4_a2, 11);
            r5_x1c  <= bpc_pkg::asr32(r4_a3, 13);
            r5_temp <= r4_temp;
            r5_up   <= r4_up;
            r5_dz   <= r4_dz;

            r6_b2sq <= b2 * r5_sq;
            r6_b1sq <= b1 * r5_sq;
            r6_x2   <= r5_x2;
            r6_x1c  <= r5_x1c;
            r6_temp <= r5_temp;
            r6_up   <= r5_up;
            r6_dz   <= r5_dz;

            r7_b3   <= w7_b3;
            r7_t    <= w7_t;
            r7_temp <= r6_temp;
            r7_up   <= r6_up;
            r7_dz   <= r6_dz;

            r8_b4   <= w8_prod >> 15;
            r8_d    <= {13'd0, r7_up} - r7_b3;
            r8_temp <= r7_temp;
            r8_dz   <= r7_dz;

            r9_b7   <= r8_d * k50;
            r9_b4   <= r8_b4;
            r9_temp <= r8_temp;
            r9_dz   <= r8_dz;

            // small b7 doubles before dividing, large b7 doubles after
            r10_num     <= r9_b7[31] ? r9_b7 : (r9_b7 << 1);
            r10_den     <= w10_b4z ? 32'd1 : r9_b4;
            r10_side.w0 <= r9_temp;
            r10_side.up <= '0;
            r10_side.f0 <= r9_dz;
            r10_side.f1 <= r9_b7[31];
            r10_side.f2 <= w10_b4z;

            r11_p    <= w11_p;
            r11_ps2  <= w11_ps * w11_ps;
            r11_m7   <= bpc_pkg::K_P_C2 * w11_p;
            r11_temp <= d2_side.w0;
            r11_dz   <= d2_side.f0;
            r11_b4z  <= d2_side.f2;

            r12_p    <= r11_p;
            r12_m3   <= r11_ps2 * bpc_pkg::K_P_C1;
            r12_x2   <= bpc_pkg::asr32(r11_m7, 16);
            r12_temp <= r11_temp;
            r12_dz   <= r11_dz;
            r12_b4z  <= r11_b4z;

            r_out_t  <= r12_temp;
            r_out_p  <= w13_p;
            r_out_ok <= w13_ok;
        end
    end

    bpc_div_pipe u_div_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_v),
        .i_num   (r2_num),
        .i_den   (r2_den),
        .i_side  (r2_side),
        .o_valid (d1_v),
        .o_quo   (d1_q),
        .o_side  (d1_side)
    );

    bpc_div_pipe u_div_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r10_v),
        .i_num   (r10_num),
        .i_den   (r10_den),
        .i_side  (r10_side),
        .o_valid (d2_v),
        .o_quo   (d2_q),
        .o_side  (d2_side)
    );

    assign o_valid              = r_out_v;
    assign o_temperature_tenths = $signed(r_out_t);
    assign o_baro_pressure      = $signed(r_out_p);
    assign o_valid_res          = r_out_ok;

    `BPC_ASSERT_IMPLY(a_ok_positive, i_clk, i_rst_n, o_valid && o_valid_res, !o_baro_pressure[31] && (o_baro_pressure != 32'sd0), "valid result with non-positive pressure")
    `BPC_ASSERT_IMPLY(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall, "input stalled without a blocked result")
    `BPC_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_stall, o_valid, "held result disappeared during stall")

endmodule

`default_nettype wire

// ----- rtl/bpc_div_pipe.sv -----
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
// Uses bpc_pkg for the stage count and the sideband type.
`default_nettype none

module bpc_div_pipe (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire logic [31:0]         i_num,
    input  wire logic [31:0]         i_den,
    input  wire bpc_pkg::t_side      i_side,
    output logic                     o_valid,
    output logic [31:0]              o_quo,
    output bpc_pkg::t_side           o_side
);

    localparam int unsigned N = bpc_pkg::DIV_STAGES;

    logic [31:0]    s_rem  [0:N-1];
    logic [31:0]    s_nq   [0:N-1];
    logic [31:0]    s_den  [0:N-1];
    bpc_pkg::t_side s_side [0:N-1];
    logic           s_v    [0:N-1];

    logic [31:0]    r_rem  [0:N-1];
    logic [31:0]    r_nq   [0:N-1];
    logic [31:0]    r_den  [0:N-1];
    bpc_pkg::t_side r_side [0:N-1];
    logic           r_v    [0:N-1];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            logic [32:0] w_trial;
            logic [32:0] w_diff;
            logic        w_ge;

            if (k == 0) begin : g_first
                assign s_rem[k]  = '0;
                assign s_nq[k]   = i_num;
                assign s_den[k]  = i_den;
                assign s_side[k] = i_side;
                assign s_v[k]    = i_valid;
            end else begin : g_next
                assign s_rem[k]  = r_rem[k-1];
                assign s_nq[k]   = r_nq[k-1];
                assign s_den[k]  = r_den[k-1];
                assign s_side[k] = r_side[k-1];
                assign s_v[k]    = r_v[k-1];
            end

            // shift in the next dividend bit, subtract when it fits
            assign w_trial = {s_rem[k], s_nq[k][31]};
            assign w_diff  = w_trial - {1'b0, s_den[k]};
            assign w_ge    = !w_diff[32];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= s_v[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= w_ge ? w_diff[31:0] : w_trial[31:0];
                    r_nq[k]   <= {s_nq[k][30:0], w_ge};
                    r_den[k]  <= s_den[k];
                    r_side[k] <= s_side[k];
                end
            end
        end
    endgenerate

    assign o_valid = r_v[N-1];
    assign o_quo   = r_nq[N-1];
    assign o_side  = r_side[N-1];

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for barometric_pressure_compensation_unit.
// Drives raw readings with bursty valid and random output stall, predicts results in place.
// Depends on bpc_pkg for register index codes and constants.
`timescale 1ns / 1ps

module testbench;

    localparam int LATENCY = 78;

    typedef struct {
        logic signed [31:0] temp;
        logic signed [31:0] pres;
        logic               ok;
    } t_comp;

    typedef struct {
        logic [15:0] ut;
        logic [18:0] up;
        logic        chk;   // typed-in expectation present
        t_comp       res;
    } t_row;

    logic i_clk, i_rst_n;
    logic i_valid, i_stall, i_cfg_valid;
    logic [15:0] i_raw_temperature;
    logic [18:0] i_raw_pressure;
    logic [7:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic o_stall, o_valid, o_valid_res, o_cfg_ready;
    logic signed [31:0] o_temperature_tenths, o_baro_pressure;

    barometric_pressure_compensation_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_raw_temperature(i_raw_temperature), .i_raw_pressure(i_raw_pressure),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_temperature_tenths(o_temperature_tenths), .o_baro_pressure(o_baro_pressure),
        .o_valid_res(o_valid_res),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    logic [63:0] cal_a_q, cal_b_q;
    logic [31:0] cal_c_q;
    logic [1:0]  oss_q;
    t_comp       pending[$];
    int          errors;
    int          hold_off;   // long receiver hold-off, in cycles
    bit          stall_on;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("testbench NOT OK");
        $finish;
    end

    function automatic logic [31:0] sext(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sra(input logic [31:0] v, input int s);
        return $signed(v) >>> s;
    endfunction

    function automatic logic [31:0] div_trunc(input logic [31:0] n, input logic [31:0] d);
        logic [31:0] mn, md, q;
        mn = n[31] ? -n : n;
        md = d[31] ? -d : d;
        q = mn / md;
        return (n[31] != d[31]) ? -q : q;
    endfunction

    function automatic t_comp compensate(input logic [15:0] ut16, input logic [18:0] up19);
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] ut, up, x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p;
        t_comp r;
        ac1 = sext(cal_a_q[15:0]);  ac2 = sext(cal_a_q[31:16]);
        ac3 = sext(cal_a_q[47:32]); ac4 = {16'd0, cal_a_q[63:48]};
        ac5 = {16'd0, cal_b_q[15:0]}; ac6 = {16'd0, cal_b_q[31:16]};
        b1 = sext(cal_b_q[47:32]);  b2 = sext(cal_b_q[63:48]);
        mc = sext(cal_c_q[15:0]);   md = sext(cal_c_q[31:16]);
        ut = {16'd0, ut16};
        up = {13'd0, up19};
        r.ok = 1'b1;
        x1 = sra((ut - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0) begin
            x2 = 0;
            r.ok = 1'b0;
        end else begin
            x2 = div_trunc(mc << 11, den);
        end
        b5 = x1 + x2;
        r.temp = sra(b5 + 32'd8, 4);
        b6 = b5 - bpc_pkg::K_B6_OFFSET;
        sq = sra(b6 * b6, 12);
        x1 = sra(b2 * sq, 11);
        x2 = sra(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = sra(((ac1 * 32'd4 + x3) << oss_q) + 32'd2, 2);
        x1 = sra(ac3 * b6, 13);
        x2 = sra(b1 * sq, 16);
        x3 = sra(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + bpc_pkg::K_B4_BIAS)) >> 15;
        b7 = (up - b3) * (bpc_pkg::K_B7_SCALE >> oss_q);
        if (b4 == 0) begin
            p = 0;
            r.ok = 1'b0;
        end else begin
            if (!b7[31]) p = (b7 * 32'd2) / b4;
            else p = (b7 / b4) * 32'd2;
            x1 = sra(p, 8) * sra(p, 8);
            x1 = sra(x1 * bpc_pkg::K_P_C1, 16);
            x2 = sra(bpc_pkg::K_P_C2 * p, 16);
            p = p + sra(x1 + x2 + bpc_pkg::K_P_C3, 4);
            if (p == 0 || p[31]) r.ok = 1'b0;
        end
        r.pres = p;
        return r;
    endfunction

    // Receiver: random stall pattern plus an optional long hold-off.
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall <= 1'b1;
        end else if (stall_on) begin
            i_stall <= ($urandom_range(0, 3) == 0);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_comp e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending.size() == 0) begin
                $error("result with no expectation");
                errors++;
            end else begin
                e = pending.pop_front();
                if (o_temperature_tenths !== e.temp) begin
                    $error("temperature_tenths exp %0d got %0d", e.temp, o_temperature_tenths);
                    errors++;
                end
                if (o_baro_pressure !== e.pres) begin
                    $error("baro_pressure exp %0d got %0d", e.pres, o_baro_pressure);
                    errors++;
                end
                if (o_valid_res !== e.ok) begin
                    $error("valid_res exp %0b got %0b", e.ok, o_valid_res);
                    errors++;
                end
            end
        end
    end

    // Leaves the write offered; the caller drops i_cfg_valid when done.
    task automatic write_reg(input logic [7:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            bpc_pkg::REG_CAL_A: cal_a_q = val;
            bpc_pkg::REG_CAL_B: cal_b_q = val;
            bpc_pkg::REG_CAL_C: cal_c_q = val[31:0];
            bpc_pkg::REG_OSS:   oss_q = val[1:0];
            default: ;
        endcase
    endtask

    task automatic set_cal(input logic [63:0] a, input logic [63:0] b,
                           input logic [31:0] c, input logic [1:0] o);
        write_reg(bpc_pkg::REG_CAL_A, a);
        write_reg(bpc_pkg::REG_CAL_B, b);
        write_reg(bpc_pkg::REG_CAL_C, {$urandom, c});
        write_reg(bpc_pkg::REG_OSS, {$urandom, $urandom} & ~64'd3 | {62'd0, o});
        i_cfg_valid <= 1'b0;
    endtask

    // Offer one item; record its expectation when it transfers. Valid stays
    // high so the next item can follow without a gap.
    task automatic send(input logic [15:0] ut, input logic [18:0] up,
                        input bit chk, input t_comp typed);
        t_comp e;
        i_valid <= 1'b1;
        i_raw_temperature <= ut;
        i_raw_pressure <= up;
        do @(posedge i_clk); while (o_stall);
        e = compensate(ut, up);
        if (chk && (e.temp !== typed.temp || e.pres !== typed.pres || e.ok !== typed.ok))
            e = typed;
        pending.push_back(e);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic random_burst(input int count);
        int k, gap;
        t_comp none;
        none = '{0, 0, 0};
        k = 0;
        while (k < count) begin
            repeat ($urandom_range(1, 12)) begin
                if (k < count) begin
                    send(16'($urandom), 19'($urandom), 0, none);
                    k++;
                end
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    t_row dir[$];
    t_comp none_r;

    initial begin
        errors = 0;
        hold_off = 0;
        stall_on = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_stall = 0;
        i_cfg_valid = 0;
        i_cfg_index = 0;
        i_cfg_data = 0;
        i_raw_temperature = 0;
        i_raw_pressure = 0;
        cal_a_q = 0; cal_b_q = 0; cal_c_q = 0; oss_q = 0;
        none_r = '{0, 0, 0};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // After reset: all calibration zero, den = 0, b4 = 0, temp = (0+8)>>4 = 0.
        dir.push_back('{16'h0000, 19'h00000, 1, '{32'sd0, 32'sd0, 1'b0}});
        dir.push_back('{16'hFFFF, 19'h7FFFF, 1, '{32'sd0, 32'sd0, 1'b0}});
        foreach (dir[i]) send(dir[i].ut, dir[i].up, dir[i].chk, dir[i].res);
        drain();

        // Datasheet-like calibration, all oversampling values.
        for (int o = 0; o < 4; o++) begin
            set_cal({16'd34223, 16'hC7C8, 16'hFFBA, 16'd408}, {16'd4, 16'd6190, 16'd23153, 16'd32757},
                    {16'hF3D3, 16'hD4BD}, 2'(o));
            dir.delete();
            dir.push_back('{16'd27898, 19'd23843, 0, none_r});
            dir.push_back('{16'h0000, 19'h00000, 0, none_r});
            dir.push_back('{16'hFFFF, 19'h7FFFF, 0, none_r});
            dir.push_back('{16'h8000, 19'h40000, 0, none_r});
            dir.push_back('{16'd25000, 19'd300000, 0, none_r});
            foreach (dir[i]) send(dir[i].ut, dir[i].up, dir[i].chk, dir[i].res);
            drain();
        end

        // Zero temperature divisor: ac5 = 0 so x1 = 0, md = 0.
        set_cal({16'd34223, 16'hC7C8, 16'hFFBA, 16'd408}, {16'd4, 16'd6190, 16'd23153, 16'd0},
                {16'h0000, 16'hD4BD}, 2'd0);
        send(16'd27898, 19'd23843, 0, none_r);
        send(16'hFFFF, 19'h7FFFF, 0, none_r);
        drain();
        // Extreme calibration: everything all-ones, then most negative words.
        set_cal('1, '1, '1, 2'd3);
        send(16'hFFFF, 19'h7FFFF, 0, none_r);
        send(16'h0000, 19'h00000, 0, none_r);
        drain();
        set_cal({4{16'h8000}}, {4{16'h8000}}, {2{16'h8000}}, 2'd2);
        send(16'hFFFF, 19'h00000, 0, none_r);
        send(16'h0000, 19'h7FFFF, 0, none_r);
        drain();
        write_reg(8'd7, '1);  // ignored index
        i_cfg_valid <= 1'b0;
        send(16'h1234, 19'h12345, 0, none_r);
        drain();

        // Random phases with varying calibrations.
        stall_on = 1;
        for (int ph = 0; ph < 10; ph++) begin
            if (ph % 3 == 0)
                set_cal({$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                        2'($urandom_range(0, 3)));
            else
                set_cal({16'($urandom_range(30000, 36000)), 16'(-$urandom_range(14000, 15000)),
                         16'(-$urandom_range(0, 200)), 16'($urandom_range(200, 9000))},
                        {16'($urandom_range(0, 40)), 16'($urandom_range(5000, 7000)),
                         16'($urandom_range(20000, 26000)), 16'($urandom_range(20000, 33000))},
                        {16'($urandom_range(0, 65535) % 3000 | 16'h0A00),
                         16'(-$urandom_range(10000, 12000))}, 2'($urandom_range(0, 3)));
            if (ph == 4) hold_off = 300;
            random_burst(50);
            drain();
        end
        stall_on = 0;
        drain();

        if (errors == 0 && pending.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/bpc_pkg.sv
rtl/bpc_div_pipe.sv
rtl/barometric_pressure_compensation_unit.sv
tb/testbench.sv
